/* rtl/core/edf_pkg.sv */
// Package for the escaped frame deframer: escape constants, verdict codes
// and the per-item result record. No dependencies.
package edf_pkg;

    localparam logic [7:0] ESC_BYTE = 8'h02;
    localparam logic [7:0] ESC_MASK = 8'h10;
    localparam logic [7:0] END_BYTE_RESET = 8'h03;

    // Position of the header bytes in the decoded stream
    localparam logic [5:0] IDX_LENGTH   = 6'd1;
    localparam logic [5:0] IDX_CHECKSUM = 6'd2;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_TERM = 2'd1,
        STATUS_EXHAUST  = 2'd2,
        STATUS_BAD_SUM  = 2'd3
    } status_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] decoded_byte;
        logic [5:0] byte_index;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

endpackage

/* rtl/core/escaped_frame_deframer.sv */
// Escaped frame deframer: byte unstuffing, header capture, XOR checksum and
// terminator check, one raw byte per transfer. Depends on edf_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | rx_byte, is_start
//  out     | output    | out_valid / out_stall| byte_valid, decoded_byte,
//          |           |                      | byte_index, frame_done,
//          |           |                      | frame_status
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (end byte)
//
// Every input transfer yields exactly one output transfer; its result is
// registered, in the skid register if an older result still waits.
// With no output stall a new byte is taken every cycle.
// The frame state updates in the same cycle a byte is taken; the decode is a
// few byte compares, an XOR and a 9-bit length compare.
// A two-entry output (result register plus skid register) lets a byte enter
// while a result waits; in_stall rises only when both entries are full.
// rst_n clears the frame state, both output entries and sets the end byte
// back to 0x03.
module escaped_frame_deframer #(
    parameter int MAX_RAW_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       is_start,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       byte_valid,
    output logic [7:0] decoded_byte,
    output logic [5:0] byte_index,
    output logic       frame_done,
    output logic [1:0] frame_status,
    // configuration channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import edf_pkg::*;

    // raw_count never exceeds MAX_RAW_BYTES-1
    localparam int RW = $clog2(MAX_RAW_BYTES);
    localparam logic [RW-1:0] RAW_LIMIT = RW'(MAX_RAW_BYTES - 1);

    // configuration
    logic [7:0] end_byte_reg;

    // frame state
    logic          in_frame_reg,       in_frame_next;
    logic          escape_pending_reg, escape_pending_next;
    logic [5:0]    decoded_count_reg,  decoded_count_next;
    logic [RW-1:0] raw_count_reg,      raw_count_next;
    logic [7:0]    frame_length_reg,   frame_length_next;
    logic [7:0]    xor_acc_reg,        xor_acc_next;
    logic [7:0]    rx_checksum_reg,    rx_checksum_next;

    // output entries
    logic    out_valid_reg,  out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg,   out_data_next;
    result_t skid_data_reg,  skid_data_next;

    result_t       res;
    logic          in_take;
    logic          out_take;
    logic          term_due;
    logic          have;
    logic [7:0]    dec;
    logic [RW-1:0] raw_inc;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // Terminator is due once length+3 bytes are decoded
    assign term_due = {3'b000, decoded_count_reg} >= ({1'b0, frame_length_reg} + 9'd3);
    assign raw_inc  = raw_count_reg + RW'(1);

    // Per-byte decode and frame state update
    always_comb
    begin
        in_frame_next       = in_frame_reg;
        escape_pending_next = escape_pending_reg;
        decoded_count_next  = decoded_count_reg;
        raw_count_next      = raw_count_reg;
        frame_length_next   = frame_length_reg;
        xor_acc_next        = xor_acc_reg;
        rx_checksum_next    = rx_checksum_reg;
        res                 = '0;
        have                = 1'b0;
        dec                 = 8'h00;

        if (is_start)
        begin
            // open a new frame, drop any frame in progress
            in_frame_next       = 1'b1;
            escape_pending_next = 1'b0;
            decoded_count_next  = '0;
            raw_count_next      = '0;
            frame_length_next   = '0;
            xor_acc_next        = '0;
            rx_checksum_next    = '0;
        end
        else if (in_frame_reg)
        begin
            raw_count_next = raw_inc;
            if (term_due)
            begin
                // terminator compared raw, never unescaped
                res.frame_done = 1'b1;
                in_frame_next  = 1'b0;
                if (rx_byte != end_byte_reg)
                    res.frame_status = STATUS_BAD_TERM;
                else if (xor_acc_reg == rx_checksum_reg)
                    res.frame_status = STATUS_OK;
                else
                    res.frame_status = STATUS_BAD_SUM;
            end
            else
            begin
                if (escape_pending_reg)
                begin
                    dec                 = rx_byte ^ ESC_MASK;
                    have                = 1'b1;
                    escape_pending_next = 1'b0;
                end
                else if (rx_byte == ESC_BYTE)
                begin
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    dec  = rx_byte;
                    have = 1'b1;
                end

                if (have)
                begin
                    if (decoded_count_reg == IDX_LENGTH)
                        frame_length_next = dec;
                    if (decoded_count_reg == IDX_CHECKSUM)
                        rx_checksum_next = dec;
                    else
                        xor_acc_next = xor_acc_reg ^ dec;
                    res.byte_valid     = 1'b1;
                    res.decoded_byte   = dec;
                    res.byte_index     = decoded_count_reg;
                    decoded_count_next = decoded_count_reg + 6'd1;
                end

                // raw buffer bound: end the frame, keep any byte decoded now
                if (raw_inc >= RAW_LIMIT)
                begin
                    res.frame_done   = 1'b1;
                    res.frame_status = STATUS_EXHAUST;
                    in_frame_next    = 1'b0;
                end
            end
        end
    end

    // Output register plus skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                // advance the waiting result
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end

        if (in_take)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                // hold the new result behind the stalled one
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_byte_reg       <= END_BYTE_RESET;
            in_frame_reg       <= 1'b0;
            escape_pending_reg <= 1'b0;
            decoded_count_reg  <= '0;
            raw_count_reg      <= '0;
            frame_length_reg   <= '0;
            xor_acc_reg        <= '0;
            rx_checksum_reg    <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                end_byte_reg <= cfg_data;
            if (in_take)
            begin
                in_frame_reg       <= in_frame_next;
                escape_pending_reg <= escape_pending_next;
                decoded_count_reg  <= decoded_count_next;
                raw_count_reg      <= raw_count_next;
                frame_length_reg   <= frame_length_next;
                xor_acc_reg        <= xor_acc_next;
                rx_checksum_reg    <= rx_checksum_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign byte_valid   = out_data_reg.byte_valid;
    assign decoded_byte = out_data_reg.decoded_byte;
    assign byte_index   = out_data_reg.byte_index;
    assign frame_done   = out_data_reg.frame_done;
    assign frame_status = out_data_reg.frame_status;

endmodule
